FILE: rtl/pesd_pkg.sv
// Shared constants and types for the pointer event queue and swipe detector.
`default_nettype none

package pesd_pkg;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned CFG_BITS    = 12;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam int unsigned CMD_DEPTH    = 2;
  localparam int unsigned CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  // width/6 == (width * 43691) >> 18 for every 12-bit width
  localparam int unsigned EDGE_RECIP = 43691;
  localparam int unsigned EDGE_SHIFT = 18;
  localparam int unsigned PROD_BITS  = 30;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST = CFG_BITS'(480);
  localparam logic [CFG_BITS-1:0] THRESHOLD_RST    = CFG_BITS'(40);

  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD    = 1'b1;

  localparam logic [2:0] KIND_MOTION   = 3'd0;
  localparam logic [2:0] KIND_DOWN     = 3'd1;
  localparam logic [2:0] KIND_UP       = 3'd2;
  localparam logic [2:0] KIND_SAMPLE   = 3'd3;
  localparam logic [2:0] KIND_SUPPRESS = 3'd4;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_NEXT = 2'd1;
  localparam logic [1:0] ACT_PREV = 2'd2;

  typedef enum logic [2:0] {
    OP_MOTION,
    OP_DOWN,
    OP_UP,
    OP_SAMPLE,
    OP_SUPPRESS
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e               op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  pressed;
    logic                  motion;
  } ring_entry_t;

endpackage

`default_nettype wire

FILE: rtl/pesd_front.sv
// Front end: decodes incoming requests and buffers them in a short command queue.
`default_nettype none

module pesd_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [2:0]                       kind_i,
  input  wire logic [pesd_pkg::COORD_BITS-1:0]  x_i,
  input  wire logic [pesd_pkg::COORD_BITS-1:0]  y_i,
  output logic                                  cmd_valid_o,
  input  wire logic                             cmd_ready_i,
  output pesd_pkg::cmd_t                        cmd_o
);

  pesd_pkg::cmd_t                           fifo_q [pesd_pkg::CMD_DEPTH];
  logic [pesd_pkg::CMD_PTR_BITS-1:0]        wr_ptr_q, wr_ptr_d;
  logic [pesd_pkg::CMD_PTR_BITS-1:0]        rd_ptr_q, rd_ptr_d;
  logic [pesd_pkg::CMD_CNT_BITS-1:0]        count_q, count_d;
  logic                                     known;
  pesd_pkg::cmd_op_e                        op;
  logic                                     push, pop;

  // unused kinds are taken and dropped here
  always_comb begin
    known = 1'b1;
    op    = pesd_pkg::OP_MOTION;
    case (kind_i)
      pesd_pkg::KIND_MOTION:   op = pesd_pkg::OP_MOTION;
      pesd_pkg::KIND_DOWN:     op = pesd_pkg::OP_DOWN;
      pesd_pkg::KIND_UP:       op = pesd_pkg::OP_UP;
      pesd_pkg::KIND_SAMPLE:   op = pesd_pkg::OP_SAMPLE;
      pesd_pkg::KIND_SUPPRESS: op = pesd_pkg::OP_SUPPRESS;
      default:                 known = 1'b0;
    endcase
  end

  assign in_ready_o  = (count_q != pesd_pkg::CMD_CNT_BITS'(pesd_pkg::CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o && known;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pesd_pkg::CMD_PTR_BITS'(pesd_pkg::CMD_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pesd_pkg::CMD_PTR_BITS'(pesd_pkg::CMD_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, x: x_i, y: y_i};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pesd_back.sv
// Back end: event ring, sample handling, swipe tracker and result register.
`default_nettype none

module pesd_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [pesd_pkg::CFG_BITS-1:0]    cfg_wdata_i,
  input  wire logic                             cmd_valid_i,
  output logic                                  cmd_ready_o,
  input  pesd_pkg::cmd_t                        cmd_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [pesd_pkg::COORD_BITS-1:0]       point_x_o,
  output logic [pesd_pkg::COORD_BITS-1:0]       point_y_o,
  output logic                                  is_pressed_o,
  output logic                                  more_pending_o,
  output logic [1:0]                            swipe_action_o,
  output logic                                  show_arrows_o
);

  localparam int unsigned CB = pesd_pkg::COORD_BITS;
  localparam int unsigned PB = pesd_pkg::PTR_BITS;
  localparam int unsigned WB = pesd_pkg::CFG_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_SAMPLE
  } state_e;

  function automatic logic [PB-1:0] ring_next(input logic [PB-1:0] i);
    ring_next = (i == PB'(pesd_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [PB-1:0] ring_prev(input logic [PB-1:0] i);
    ring_prev = (i == '0) ? PB'(pesd_pkg::QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  // ring storage
  pesd_pkg::ring_entry_t ring_mem_q [pesd_pkg::QUEUE_DEPTH];
  pesd_pkg::ring_entry_t rd_data_q;
  pesd_pkg::ring_entry_t wr_entry;
  logic [PB-1:0]         wr_addr;
  logic                  mem_we, mem_re;

  state_e        state_q, state_d;
  logic [PB-1:0] head_q, head_d, tail_q, tail_d;
  logic          newest_motion_q, newest_motion_d;
  logic          lqp_q, lqp_d;
  logic          hit_q, hit_d;

  logic [WB-1:0] width_q, width_d, thr_q, thr_d;
  logic [WB-1:0] margin_q, right_q;
  logic [pesd_pkg::PROD_BITS-1:0] prod;
  logic [WB-1:0] margin_d;

  logic [CB-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic          cur_p_q, cur_p_d;
  logic          active_q, active_d, done_q, done_d, sup_q, sup_d;
  logic [CB-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CB-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    act_q, act_d;
  logic          arrows_q, arrows_d;
  logic          pend_q, pend_d;

  logic          empty, full, merge, is_motion, finish;
  logic          dx_neg;
  logic [CB-1:0] adx, ady;

  assign empty     = (head_q == tail_q);
  assign full      = (ring_next(head_q) == tail_q);
  assign is_motion = (cmd_i.op == pesd_pkg::OP_MOTION);
  assign merge     = is_motion && !empty && newest_motion_q;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign finish      = (state_q == ST_SAMPLE) && (!out_valid_q || out_ready_i);

  // edge margin, refreshed from the width register every cycle
  assign prod     = pesd_pkg::PROD_BITS'(width_q) *
                    pesd_pkg::PROD_BITS'(pesd_pkg::EDGE_RECIP);
  assign margin_d = prod[pesd_pkg::EDGE_SHIFT +: WB];

  assign dx_neg = (last_x_q < start_x_q);
  assign adx    = dx_neg ? (start_x_q - last_x_q) : (last_x_q - start_x_q);
  assign ady    = (last_y_q < start_y_q) ? (start_y_q - last_y_q) : (last_y_q - start_y_q);

  always_comb begin
    state_d         = state_q;
    head_d          = head_q;
    tail_d          = tail_q;
    newest_motion_d = newest_motion_q;
    lqp_d           = lqp_q;
    hit_d           = hit_q;
    width_d         = width_q;
    thr_d           = thr_q;
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    cur_p_d         = cur_p_q;
    active_d        = active_q;
    done_d          = done_q;
    sup_d           = sup_q;
    start_x_d       = start_x_q;
    start_y_d       = start_y_q;
    last_x_d        = last_x_q;
    last_y_d        = last_y_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    act_d           = act_q;
    arrows_d        = arrows_q;
    pend_d          = pend_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    wr_addr         = head_q;
    wr_entry        = '{x: cmd_i.x, y: cmd_i.y, pressed: lqp_q, motion: 1'b1};

    if (cfg_we_i) begin
      if (cfg_idx_i == pesd_pkg::REG_SCREEN_WIDTH) begin
        width_d = cfg_wdata_i;
      end else begin
        thr_d = cfg_wdata_i;
      end
    end

    if (cmd_valid_i && cmd_ready_o) begin
      case (cmd_i.op)
        pesd_pkg::OP_MOTION, pesd_pkg::OP_DOWN, pesd_pkg::OP_UP: begin
          if (!is_motion) begin
            wr_entry.pressed = (cmd_i.op == pesd_pkg::OP_DOWN);
            wr_entry.motion  = 1'b0;
          end
          if (merge) begin
            // newest entry is a motion: overwrite its coordinates
            mem_we  = 1'b1;
            wr_addr = ring_prev(head_q);
          end else if (!full) begin
            mem_we          = 1'b1;
            head_d          = ring_next(head_q);
            newest_motion_d = is_motion;
            if (!is_motion) begin
              lqp_d = wr_entry.pressed;
            end
          end
        end
        pesd_pkg::OP_SUPPRESS: begin
          sup_d = 1'b1;
        end
        pesd_pkg::OP_SAMPLE: begin
          hit_d   = !empty;
          mem_re  = !empty;
          if (!empty) begin
            tail_d = ring_next(tail_q);
          end
          state_d = ST_SAMPLE;
        end
        default: ;
      endcase
    end

    if (finish) begin
      state_d  = ST_IDLE;
      act_d    = pesd_pkg::ACT_NONE;
      arrows_d = 1'b0;
      if (hit_q) begin
        cur_x_d = rd_data_q.x;
        cur_y_d = rd_data_q.y;
        if (!rd_data_q.motion) begin
          cur_p_d = rd_data_q.pressed;
        end
      end
      if (cur_p_d) begin
        last_x_d = cur_x_d;
        last_y_d = cur_y_d;
        if (!active_q) begin
          active_d  = 1'b1;
          done_d    = 1'b0;
          sup_d     = 1'b0;
          start_x_d = cur_x_d;
          start_y_d = cur_y_d;
          arrows_d  = 1'b1;
        end
      end else begin
        if (active_q && !done_q && (adx >= CB'(thr_q)) && (adx > ady) &&
            (start_x_q > CB'(margin_q)) && (start_x_q < CB'(right_q)) && !sup_q) begin
          done_d = 1'b1;
          act_d  = dx_neg ? pesd_pkg::ACT_NEXT : pesd_pkg::ACT_PREV;
        end
        active_d = 1'b0;
      end
      pend_d      = !empty;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      head_q          <= '0;
      tail_q          <= '0;
      newest_motion_q <= 1'b0;
      lqp_q           <= 1'b0;
      hit_q           <= 1'b0;
      width_q         <= pesd_pkg::SCREEN_WIDTH_RST;
      thr_q           <= pesd_pkg::THRESHOLD_RST;
      margin_q        <= WB'(480 / 6);
      right_q         <= WB'(480 - 480 / 6);
      cur_x_q         <= '0;
      cur_y_q         <= '0;
      cur_p_q         <= 1'b0;
      active_q        <= 1'b0;
      done_q          <= 1'b0;
      sup_q           <= 1'b0;
      start_x_q       <= '0;
      start_y_q       <= '0;
      last_x_q        <= '0;
      last_y_q        <= '0;
      out_valid_q     <= 1'b0;
      act_q           <= pesd_pkg::ACT_NONE;
      arrows_q        <= 1'b0;
      pend_q          <= 1'b0;
    end else begin
      state_q         <= state_d;
      head_q          <= head_d;
      tail_q          <= tail_d;
      newest_motion_q <= newest_motion_d;
      lqp_q           <= lqp_d;
      hit_q           <= hit_d;
      width_q         <= width_d;
      thr_q           <= thr_d;
      margin_q        <= margin_d;
      right_q         <= width_q - margin_d;
      cur_x_q         <= cur_x_d;
      cur_y_q         <= cur_y_d;
      cur_p_q         <= cur_p_d;
      active_q        <= active_d;
      done_q          <= done_d;
      sup_q           <= sup_d;
      start_x_q       <= start_x_d;
      start_y_q       <= start_y_d;
      last_x_q        <= last_x_d;
      last_y_q        <= last_y_d;
      out_valid_q     <= out_valid_d;
      act_q           <= act_d;
      arrows_q        <= arrows_d;
      pend_q          <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem_q[wr_addr] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem_q[tail_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = cur_x_q;
  assign point_y_o      = cur_y_q;
  assign is_pressed_o   = cur_p_q;
  assign more_pending_o = pend_q;
  assign swipe_action_o = act_q;
  assign show_arrows_o  = arrows_q;

endmodule

`default_nettype wire

FILE: rtl/pointer_event_queue_swipe_detect_unit.sv
// A sample request passes the command queue, the registered ring read and the result register.
// Throughput: one event a cycle while the back end is idle; a sample request holds the back end
// in its sample state for the registered read of the 64-entry event ring and until the result register is free.
// A 2-entry command queue lets the input side keep taking requests meanwhile.
// Reset (async, active low) clears pointers, tracker state and config to defaults;
// ring contents are left as they are and need no clearing pass.
`default_nettype none

module pointer_event_queue_swipe_detect_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [pesd_pkg::CFG_BITS-1:0]    cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [2:0]                       kind_i,
  input  wire logic [pesd_pkg::COORD_BITS-1:0]  x_i,
  input  wire logic [pesd_pkg::COORD_BITS-1:0]  y_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [pesd_pkg::COORD_BITS-1:0]       point_x_o,
  output logic [pesd_pkg::COORD_BITS-1:0]       point_y_o,
  output logic                                  is_pressed_o,
  output logic                                  more_pending_o,
  output logic [1:0]                            swipe_action_o,
  output logic                                  show_arrows_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  pesd_pkg::cmd_t cmd;

  pesd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pesd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .is_pressed_o   (is_pressed_o),
    .more_pending_o (more_pending_o),
    .swipe_action_o (swipe_action_o),
    .show_arrows_o  (show_arrows_o)
  );

endmodule

`default_nettype wire

FILE: tb/pointer_event_queue_swipe_detect_unit_test.sv
// Testbench for the pointer event queue and swipe detector, checked against its own predictor.
`default_nettype none

module pointer_event_queue_swipe_detect_unit_test;
  import pesd_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int unsigned EDGE_DIVISOR    = 6;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned PRESSURE_PHASE  = 2;
  localparam int unsigned EVENTS_PER_PHASE = 260;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned COORD_MAX       = (1 << COORD_BITS) - 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic       pressed;
    logic       more;
    logic [1:0] action;
    logic       arrows;
  } sample_report_t;

  typedef struct packed {
    logic [2:0] kind;
    coord_t     x;
    coord_t     y;
  } pointer_req_t;

  typedef struct packed {
    pointer_req_t   req;
    logic           typed;
    sample_report_t rep;
  } directed_row_t;

  localparam sample_report_t NO_REPORT = '0;
  localparam int unsigned NUM_DIRECTED = 27;

  // typed expectations only where the result is obvious; other rows use the predictor
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b1, '{12'd0, 12'd0, 1'b0, 1'b0, ACT_NONE, 1'b0}},
    '{'{KIND_DOWN,     12'd4095, 12'd4095}, 1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd4095, 12'd4095}, 1'b1,
      '{12'd4095, 12'd4095, 1'b1, 1'b0, ACT_NONE, 1'b1}},
    '{'{KIND_UP,       12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b1, '{12'd0, 12'd0, 1'b0, 1'b0, ACT_NONE, 1'b0}},
    '{'{KIND_DOWN,     12'd240,  12'd100},  1'b0, NO_REPORT},
    '{'{KIND_MOTION,   12'd300,  12'd120},  1'b0, NO_REPORT},
    '{'{KIND_MOTION,   12'd100,  12'd110},  1'b0, NO_REPORT},
    '{'{KIND_UP,       12'd100,  12'd110},  1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_DOWN,     12'd200,  12'd50},   1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SUPPRESS, 12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_MOTION,   12'd400,  12'd60},   1'b0, NO_REPORT},
    '{'{KIND_UP,       12'd400,  12'd60},   1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_UNUSED_LO, 12'd4095, 12'd4095}, 1'b0, NO_REPORT},
    '{'{KIND_UNUSED_HI, 12'd1234, 12'd777},  1'b0, NO_REPORT},
    '{'{KIND_DOWN,     12'd240,  12'd0},    1'b0, NO_REPORT},
    '{'{KIND_MOTION,   12'd300,  12'd0},    1'b0, NO_REPORT},
    '{'{KIND_UP,       12'd300,  12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT},
    '{'{KIND_SAMPLE,   12'd0,    12'd0},    1'b0, NO_REPORT}
  };

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic               cfg_idx_i    = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [2:0]         kind_i       = KIND_MOTION;
  coord_t             x_i          = '0;
  coord_t             y_i          = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  coord_t             point_x_o;
  coord_t             point_y_o;
  logic               is_pressed_o;
  logic               more_pending_o;
  logic [1:0]         swipe_action_o;
  logic               show_arrows_o;

  pointer_event_queue_swipe_detect_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .x_i            (x_i),
    .y_i            (y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .is_pressed_o   (is_pressed_o),
    .more_pending_o (more_pending_o),
    .swipe_action_o (swipe_action_o),
    .show_arrows_o  (show_arrows_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  coord_t      ring_x     [QUEUE_DEPTH];
  coord_t      ring_y     [QUEUE_DEPTH];
  logic        ring_press [QUEUE_DEPTH];
  logic        ring_motion[QUEUE_DEPTH];
  int unsigned wr_ptr, rd_ptr;
  logic        queued_press;
  coord_t      pos_x, pos_y;
  logic        pos_press;
  logic        trk_active, trk_done, trk_suppress;
  coord_t      anchor_x, anchor_y, latest_x, latest_y;
  coord_t      cfg_width, cfg_threshold;

  sample_report_t expected_reports[$];
  pointer_req_t   pending_events[$];
  int unsigned    counted_events;
  int unsigned    mismatch_count;

  bit          send_idle_on;
  logic        recv_idle_on = 1'b0;
  logic        hold_phase   = 1'b0;
  int unsigned hold_count   = 0;
  int unsigned stall_left   = 0;

  function automatic int unsigned wrap_inc(int unsigned p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic void enqueue_pointer(coord_t x, coord_t y, logic pressed, logic motion);
    int unsigned newest;
    newest = (wr_ptr == 0) ? QUEUE_DEPTH - 1 : wr_ptr - 1;
    // consecutive motions collapse into the newest entry
    if (motion && wr_ptr != rd_ptr && ring_motion[newest]) begin
      ring_x[newest] = x;
      ring_y[newest] = y;
      return;
    end
    if (wrap_inc(wr_ptr) == rd_ptr) return;
    ring_x[wr_ptr]      = x;
    ring_y[wr_ptr]      = y;
    ring_press[wr_ptr]  = pressed;
    ring_motion[wr_ptr] = motion;
    wr_ptr = wrap_inc(wr_ptr);
    if (!motion) queued_press = pressed;
  endfunction

  function automatic bit predict_report(pointer_req_t req, output sample_report_t rep);
    coord_t adx, ady, margin;
    logic   off_edge;
    rep = '0;
    case (req.kind)
      KIND_MOTION: begin
        enqueue_pointer(req.x, req.y, queued_press, 1'b1);
        return 1'b0;
      end
      KIND_DOWN: begin
        enqueue_pointer(req.x, req.y, 1'b1, 1'b0);
        return 1'b0;
      end
      KIND_UP: begin
        enqueue_pointer(req.x, req.y, 1'b0, 1'b0);
        return 1'b0;
      end
      KIND_SUPPRESS: begin
        trk_suppress = 1'b1;
        return 1'b0;
      end
      KIND_SAMPLE: ;
      default: return 1'b0;
    endcase
    if (wr_ptr != rd_ptr) begin
      pos_x = ring_x[rd_ptr];
      pos_y = ring_y[rd_ptr];
      if (!ring_motion[rd_ptr]) pos_press = ring_press[rd_ptr];
      rd_ptr = wrap_inc(rd_ptr);
    end
    if (pos_press) begin
      latest_x = pos_x;
      latest_y = pos_y;
      if (!trk_active) begin
        trk_active   = 1'b1;
        trk_done     = 1'b0;
        trk_suppress = 1'b0;
        anchor_x     = pos_x;
        anchor_y     = pos_y;
        rep.arrows   = 1'b1;
      end
    end else begin
      if (trk_active && !trk_done) begin
        adx = (latest_x < anchor_x) ? anchor_x - latest_x : latest_x - anchor_x;
        ady = (latest_y < anchor_y) ? anchor_y - latest_y : latest_y - anchor_y;
        margin = coord_t'(cfg_width / EDGE_DIVISOR);
        off_edge = (anchor_x > margin) && (anchor_x < cfg_width - margin);
        if (adx >= cfg_threshold && adx > ady && off_edge && !trk_suppress) begin
          trk_done   = 1'b1;
          rep.action = (latest_x < anchor_x) ? ACT_NEXT : ACT_PREV;
        end
      end
      trk_active = 1'b0;
    end
    rep.x       = pos_x;
    rep.y       = pos_y;
    rep.pressed = pos_press;
    rep.more    = (wr_ptr != rd_ptr);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [COORD_BITS-1:0] want,
                                      logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    sample_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected, expected nothing, got x=%0d y=%0d",
                 $time, point_x_o, point_y_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("point_x", want.x, point_x_o);
        check_field("point_y", want.y, point_y_o);
        check_field("is_pressed", coord_t'(want.pressed), coord_t'(is_pressed_o));
        check_field("more_pending", coord_t'(want.more), coord_t'(more_pending_o));
        check_field("swipe_action", coord_t'(want.action), coord_t'(swipe_action_o));
        check_field("show_arrows", coord_t'(want.arrows), coord_t'(show_arrows_o));
      end
    end
  end

  // receiver: one long hold-off when asked, else random stall bursts while enabled
  always @(posedge clk_i) begin
    if (hold_phase && hold_count < LONG_HOLD) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_request(pointer_req_t req, logic typed, sample_report_t typed_rep);
    sample_report_t rep;
    in_valid_i <= 1'b1;
    kind_i     <= req.kind;
    x_i        <= req.x;
    y_i        <= req.y;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_report(req, rep)) expected_reports.push_back(typed ? typed_rep : rep);
  endtask

  task automatic pause_input(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_reports();
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
    end while (expected_reports.size() != 0 && n < DRAIN_LIMIT);
  endtask

  task automatic write_reg(logic idx, logic [CFG_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_SCREEN_WIDTH) cfg_width = value;
    else cfg_threshold = value;
  endtask

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic void add_event(logic [2:0] kind, int x, int y);
    pointer_req_t req;
    req.kind = kind;
    req.x    = clamp_coord(x);
    req.y    = clamp_coord(y);
    pending_events.push_back(req);
    if (kind <= KIND_SUPPRESS) counted_events++;
  endfunction

  // press, up to four drags, release, then enough samples to roughly drain the queue
  function automatic void add_gesture();
    int px, py, moves, queued, sampled;
    px = $urandom_range(0, 1) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, cfg_width);
    py = $urandom_range(0, COORD_MAX);
    queued  = 1;
    sampled = 0;
    add_event(KIND_DOWN, px, py);
    if ($urandom_range(0, 2) == 0) begin
      add_event(KIND_SAMPLE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      sampled++;
    end
    moves = $urandom_range(0, 4);
    for (int i = 0; i < moves; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        px = $urandom_range(0, COORD_MAX);
        py = $urandom_range(0, COORD_MAX);
      end else begin
        px = px + $urandom_range(0, 600) - 300;
        py = py + $urandom_range(0, 120) - 60;
      end
      add_event(KIND_MOTION, px, py);
      queued++;
      if ($urandom_range(0, 1)) begin
        add_event(KIND_SAMPLE, 0, 0);
        sampled++;
      end
      if ($urandom_range(0, 9) == 0) add_event(KIND_SUPPRESS, px, py);
    end
    if ($urandom_range(0, 1)) add_event(KIND_UP, px, py);
    else add_event(KIND_UP, px + $urandom_range(0, 40) - 20, py + $urandom_range(0, 40) - 20);
    queued++;
    for (int i = sampled; i < queued + int'($urandom_range(0, 1)); i++)
      add_event(KIND_SAMPLE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endfunction

  // overfill the ring with button events, then drain it
  function automatic void add_flood();
    for (int i = 0; i < 70; i++)
      add_event(i[0] ? KIND_UP : KIND_DOWN, $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX));
    add_event(KIND_MOTION, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    for (int i = 0; i < 72; i++) add_event(KIND_SAMPLE, 0, 0);
  endfunction

  task automatic run_events(bit last, bit pause_mid);
    int unsigned total;
    total = pending_events.size();
    for (int unsigned i = 0; i < total; i++) begin
      send_request(pending_events.pop_front(), 1'b0, NO_REPORT);
      if (!last && $urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
      if (!last && $urandom_range(0, 63) == 0) recv_idle_on <= !recv_idle_on;
      if (pause_mid && i == total / 2) wait_reports();
      else if (send_idle_on && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] width_sel, thr_sel;
    wr_ptr = 0; rd_ptr = 0; queued_press = 1'b0;
    pos_x = '0; pos_y = '0; pos_press = 1'b0;
    trk_active = 1'b0; trk_done = 1'b0; trk_suppress = 1'b0;
    anchor_x = '0; anchor_y = '0; latest_x = '0; latest_y = '0;
    cfg_width = SCREEN_WIDTH_RST; cfg_threshold = THRESHOLD_RST;
    mismatch_count = 0;
    send_idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni       <= 1'b1;
    recv_idle_on <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rep);
      if ($urandom_range(0, 2) == 0) pause_input($urandom_range(1, 8));
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_reports();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: begin width_sel = 12'd6;    thr_sel = 12'd0;    end
        1: begin width_sel = 12'd4095; thr_sel = 12'd4095; end
        2: begin width_sel = 12'd480;  thr_sel = 12'd40;   end
        3: begin width_sel = 12'd4095; thr_sel = 12'd0;    end
        4: begin width_sel = 12'd3;    thr_sel = 12'd100;  end
        default: begin
          width_sel = CFG_BITS'($urandom_range(6, 4095));
          thr_sel   = CFG_BITS'($urandom_range(0, 300));
        end
      endcase
      write_reg(REG_SCREEN_WIDTH, width_sel);
      write_reg(REG_THRESHOLD, thr_sel);
      send_idle_on = (ph != NUM_PHASES - 1);
      recv_idle_on <= (ph != NUM_PHASES - 1);
      counted_events = 0;
      if (ph == PRESSURE_PHASE) begin
        hold_phase <= 1'b1;
        add_flood();
      end
      while (counted_events < EVENTS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0)
          add_event(3'($urandom_range(KIND_MOTION, KIND_UNUSED_HI)),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        else
          add_gesture();
      end
      run_events(ph == NUM_PHASES - 1, ph == PRESSURE_PHASE);
    end

    wait_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: reports still outstanding, expected 0, got %0d",
               $time, expected_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("pointer_event_queue_swipe_detect_unit_test: clean");
    else
      $display("pointer_event_queue_swipe_detect_unit_test: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("pointer_event_queue_swipe_detect_unit_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
